// ----- rtl/tsm_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tsm_pkg
// Shared constants and types for the trilinear eight-source mixer.
// ============================================================================
package tsm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 15;

    localparam int NUM_SRC    = 8;
    localparam int NUM_AXES   = 3;
    localparam int MASK_BITS  = 8;
    localparam int START_BITS = 16;
    localparam int DEPTH_BITS = 17;
    localparam int MOD_BITS   = 16;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_X_START = 3'd0,
        REG_X_DEPTH = 3'd1,
        REG_Y_START = 3'd2,
        REG_Y_DEPTH = 3'd3,
        REG_Z_START = 3'd4,
        REG_Z_DEPTH = 3'd5
    } cfg_reg_t;

    localparam int NUM_REGS = 6;

    // pipeline stage indices
    localparam int STG_PROD   = 0;   // depth * modulator
    localparam int STG_POS    = 1;   // clamped axis positions
    localparam int STG_WXY    = 2;   // wx * wy
    localparam int STG_WXYZ   = 3;   // wxy * wz
    localparam int STG_TERM   = 4;   // weight * sample
    localparam int STG_PART   = 5;   // two partial sums
    localparam int STG_OUT    = 6;   // final sum, truncate, saturate
    localparam int NUM_STAGES = 7;

    typedef logic [NUM_STAGES-1:0] pipe_en_t;

    // corner coordinate bits per source: bit0 = x, bit1 = y, bit2 = z
    localparam logic [2:0] CORNER_BITS [NUM_SRC] = '{
        3'd0, 3'd1, 3'd5, 3'd4, 3'd2, 3'd3, 3'd7, 3'd6
    };

endpackage

// ----- rtl/trilinear_eight_source_mixer.sv -----
`timescale 1ns / 1ps
// ============================================================================
// trilinear_eight_source_mixer
// Eight corner samples mixed by trilinear weights from three modulated axes.
// ============================================================================
//
//  channel   dir   handshake              word
//  --------  ----  ---------------------  ----------------------------------
//  in        in    in_valid / in_stall    source_0..7, active_mask, mod_x/y/z
//  out       out   out_valid / out_stall  mixed_sample
//  cfg       in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One word per cycle sustained while out_stall stays low. The pipeline has
//  7 stages: axis multiply, clamp, two weight multiplies, sample multiply,
//  and a two-level adder tree.
//  Each stage holds only when it is full and the stage after it holds, so
//  bubbles close up and in_stall rises only once every stage is occupied.
//  Reset clears the valid bits and the axis registers; payload is not reset.
//  cfg_ready is always high; writes go straight to the axis registers.
//
module trilinear_eight_source_mixer #(
    parameter int SAMPLE_BITS = tsm_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = tsm_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       source_0,
    input  logic signed [SAMPLE_BITS-1:0]       source_1,
    input  logic signed [SAMPLE_BITS-1:0]       source_2,
    input  logic signed [SAMPLE_BITS-1:0]       source_3,
    input  logic signed [SAMPLE_BITS-1:0]       source_4,
    input  logic signed [SAMPLE_BITS-1:0]       source_5,
    input  logic signed [SAMPLE_BITS-1:0]       source_6,
    input  logic signed [SAMPLE_BITS-1:0]       source_7,
    input  logic [tsm_pkg::MASK_BITS-1:0]       active_mask,
    input  logic [tsm_pkg::MOD_BITS-1:0]        mod_x,
    input  logic [tsm_pkg::MOD_BITS-1:0]        mod_y,
    input  logic [tsm_pkg::MOD_BITS-1:0]        mod_z,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       mixed_sample,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [tsm_pkg::DEPTH_BITS-1:0]      cfg_data
);
    import tsm_pkg::*;

    localparam int TERM_W = FRAC_BITS + SAMPLE_BITS + 1;

    // axis registers
    logic [START_BITS-1:0]        start_reg [NUM_AXES];
    logic signed [DEPTH_BITS-1:0] depth_reg [NUM_AXES];

    // pipeline control
    logic [NUM_STAGES-1:0] valid_reg;
    pipe_en_t              en;

    logic signed [SAMPLE_BITS-1:0]          src [NUM_SRC];
    logic [MOD_BITS-1:0]                    mod_in [NUM_AXES];
    logic [NUM_AXES-1:0][FRAC_BITS:0]       far_pos;
    logic [NUM_AXES-1:0][FRAC_BITS:0]       near_pos;
    logic [NUM_SRC-1:0][TERM_W-1:0]         terms;

    assign src[0] = source_0;
    assign src[1] = source_1;
    assign src[2] = source_2;
    assign src[3] = source_3;
    assign src[4] = source_4;
    assign src[5] = source_5;
    assign src[6] = source_6;
    assign src[7] = source_7;

    assign mod_in[0] = mod_x;
    assign mod_in[1] = mod_y;
    assign mod_in[2] = mod_z;

    // ---- configuration -----------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                start_reg[a] <= '0;
                depth_reg[a] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_X_START: start_reg[0] <= cfg_data[START_BITS-1:0];
                REG_X_DEPTH: depth_reg[0] <= $signed(cfg_data);
                REG_Y_START: start_reg[1] <= cfg_data[START_BITS-1:0];
                REG_Y_DEPTH: depth_reg[1] <= $signed(cfg_data);
                REG_Z_START: start_reg[2] <= cfg_data[START_BITS-1:0];
                REG_Z_DEPTH: depth_reg[2] <= $signed(cfg_data);
                default: ;   // unknown index: ignored
            endcase
        end
    end

    // ---- pipeline advance --------------------------------------------------
    // A stage loads when it is empty or the next stage loads.
    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
            en[s] = !valid_reg[s] || en[s+1];
    end

    assign in_stall = !en[STG_PROD];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[STG_PROD])
                valid_reg[STG_PROD] <= in_valid;
            for (int s = 1; s < NUM_STAGES; s++)
                if (en[s])
                    valid_reg[s] <= valid_reg[s-1];
        end
    end

    // ---- datapath ----------------------------------------------------------
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        tsm_axis #(
            .FRAC_BITS (FRAC_BITS)
        ) u_axis (
            .clk      (clk),
            .en       (en),
            .start    (start_reg[a]),
            .depth    (depth_reg[a]),
            .mod_val  (mod_in[a]),
            .far_pos  (far_pos[a]),
            .near_pos (near_pos[a])
        );
    end

    for (genvar n = 0; n < NUM_SRC; n++)
    begin : g_lane
        tsm_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .FRAC_BITS   (FRAC_BITS),
            .CORNER      (CORNER_BITS[n])
        ) u_lane (
            .clk      (clk),
            .en       (en),
            .sample   (src[n]),
            .active   (active_mask[n]),
            .far_pos  (far_pos),
            .near_pos (near_pos),
            .term     (terms[n])
        );
    end

    tsm_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_merge (
        .clk   (clk),
        .en    (en),
        .terms (terms),
        .mixed (mixed_sample)
    );

    assign out_valid = valid_reg[NUM_STAGES-1];

    // ---- assertions --------------------------------------------------------
    // full pipeline behind a stalled output must stall the input
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && out_stall) |-> in_stall)
        else $error("input accepted with a full, stalled pipeline");

    // a held stage keeps its word
    a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STG_TERM] && !en[STG_TERM]) |=> valid_reg[STG_TERM])
        else $error("word dropped from a held stage");

    // an output word must come from the stage before it
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_reg[STG_PART]))
        else $error("output word appeared without a source");

    // an accepted word reaches the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[STG_PROD])
        else $error("accepted word not captured");

endmodule

// ----- rtl/tsm_axis.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tsm_axis
// One axis: start + rounded depth * modulator, clamped to 0..1.
// ============================================================================
module tsm_axis #(
    parameter int FRAC_BITS = tsm_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  tsm_pkg::pipe_en_t                       en,
    input  logic [tsm_pkg::START_BITS-1:0]          start,
    input  logic signed [tsm_pkg::DEPTH_BITS-1:0]   depth,
    input  logic [tsm_pkg::MOD_BITS-1:0]            mod_val,
    output logic [FRAC_BITS:0]                      far_pos,
    output logic [FRAC_BITS:0]                      near_pos
);
    import tsm_pkg::*;

    localparam int PROD_W = DEPTH_BITS + MOD_BITS + 1;
    localparam int AX_W   = PROD_W + 1;
    localparam logic signed [AX_W-1:0] HALF_AX = AX_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [AX_W-1:0] ONE_AX  = AX_W'(1) <<< FRAC_BITS;
    localparam logic [FRAC_BITS:0]     ONE_P   = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic [FRAC_BITS:0]       far_reg;
    logic [FRAC_BITS:0]       near_reg;
    logic signed [AX_W-1:0]   sum_w;
    logic signed [AX_W-1:0]   off_w;
    logic signed [AX_W-1:0]   pos_w;
    logic [FRAC_BITS:0]       far_next;

    always_comb
    begin
        sum_w = AX_W'(prod_reg) + HALF_AX;
        off_w = sum_w >>> FRAC_BITS;     // floor, round half up
        pos_w = $signed({{(AX_W-START_BITS){1'b0}}, start}) + off_w;
        if (pos_w < 0)
            far_next = '0;
        else if (pos_w > ONE_AX)
            far_next = ONE_P;
        else
            far_next = pos_w[FRAC_BITS:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_PROD])
            prod_reg <= depth * $signed({1'b0, mod_val});
        if (en[STG_POS])
        begin
            far_reg  <= far_next;
            near_reg <= ONE_P - far_next;
        end
    end

    assign far_pos  = far_reg;
    assign near_pos = near_reg;

endmodule

// ----- rtl/tsm_lane.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tsm_lane
// One source lane: corner weight from the three axes, times its sample.
// ============================================================================
module tsm_lane #(
    parameter int         SAMPLE_BITS = tsm_pkg::SAMPLE_BITS_DEF,
    parameter int         FRAC_BITS   = tsm_pkg::FRAC_BITS_DEF,
    parameter logic [2:0] CORNER      = 3'd0
) (
    input  logic                                          clk,
    input  tsm_pkg::pipe_en_t                             en,
    input  logic signed [SAMPLE_BITS-1:0]                 sample,
    input  logic                                          active,
    input  logic [tsm_pkg::NUM_AXES-1:0][FRAC_BITS:0]     far_pos,
    input  logic [tsm_pkg::NUM_AXES-1:0][FRAC_BITS:0]     near_pos,
    output logic signed [FRAC_BITS+SAMPLE_BITS:0]         term
);
    import tsm_pkg::*;

    localparam int W_W    = FRAC_BITS + 1;
    localparam int WP_W   = 2 * FRAC_BITS + 2;
    localparam int TERM_W = FRAC_BITS + SAMPLE_BITS + 1;
    localparam int MUL_W  = FRAC_BITS + SAMPLE_BITS + 2;
    localparam logic [WP_W-1:0] HALF_W = WP_W'(1) << (FRAC_BITS - 1);

    // sample and active bit ride along until the term stage
    logic signed [SAMPLE_BITS-1:0] sample_reg [STG_WXYZ+1];
    logic                          active_reg [STG_WXYZ+1];
    logic [WP_W-1:0]               wxy_reg;
    logic [W_W-1:0]                wz_reg;
    logic [WP_W-1:0]               w_reg;
    logic signed [TERM_W-1:0]      term_reg;

    logic [W_W-1:0]                wx;
    logic [W_W-1:0]                wy;
    logic [W_W-1:0]                wz;
    logic [WP_W-1:0]               wxy_rnd;
    logic [WP_W-1:0]               w_rnd;
    logic signed [MUL_W-1:0]       mul_w;

    always_comb
    begin
        wx      = CORNER[0] ? far_pos[0] : near_pos[0];
        wy      = CORNER[1] ? far_pos[1] : near_pos[1];
        wz      = CORNER[2] ? far_pos[2] : near_pos[2];
        wxy_rnd = (wxy_reg + HALF_W) >> FRAC_BITS;
        w_rnd   = (w_reg + HALF_W) >> FRAC_BITS;
        mul_w   = $signed({1'b0, w_rnd[W_W-1:0]}) * sample_reg[STG_WXYZ];
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_PROD])
        begin
            sample_reg[STG_PROD] <= sample;
            active_reg[STG_PROD] <= active;
        end
        for (int s = STG_POS; s <= STG_WXYZ; s++)
        begin
            if (en[s])
            begin
                sample_reg[s] <= sample_reg[s-1];
                active_reg[s] <= active_reg[s-1];
            end
        end
        if (en[STG_WXY])
        begin
            wxy_reg <= wx * wy;
            wz_reg  <= wz;
        end
        if (en[STG_WXYZ])
            w_reg <= wxy_rnd[W_W-1:0] * wz_reg;
        if (en[STG_TERM])
            term_reg <= active_reg[STG_WXYZ] ? TERM_W'(mul_w) : '0;
    end

    assign term = term_reg;

endmodule

// ----- rtl/tsm_merge.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tsm_merge
// Sums the lane terms, truncates toward zero and saturates.
// ============================================================================
module tsm_merge #(
    parameter int SAMPLE_BITS = tsm_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = tsm_pkg::FRAC_BITS_DEF
) (
    input  logic                                                    clk,
    input  tsm_pkg::pipe_en_t                                       en,
    input  logic [tsm_pkg::NUM_SRC-1:0][FRAC_BITS+SAMPLE_BITS:0]    terms,
    output logic signed [SAMPLE_BITS-1:0]                           mixed
);
    import tsm_pkg::*;

    localparam int TERM_W = FRAC_BITS + SAMPLE_BITS + 1;
    localparam int PART_W = TERM_W + 2;
    localparam int ACC_W  = TERM_W + 3;
    localparam int HALF_N = NUM_SRC / 2;
    localparam logic signed [ACC_W-1:0] ROUND_NEG = (ACC_W'(1) <<< FRAC_BITS) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);

    logic signed [PART_W-1:0]      part_reg [2];
    logic signed [SAMPLE_BITS-1:0] mixed_reg;
    logic signed [PART_W-1:0]      part_w [2];
    logic signed [ACC_W-1:0]       acc_w;
    logic signed [ACC_W-1:0]       quo_w;
    logic signed [SAMPLE_BITS-1:0] sat_w;

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            part_w[h] = '0;
            for (int i = 0; i < HALF_N; i++)
                part_w[h] = part_w[h] + PART_W'($signed(terms[h*HALF_N+i]));
        end
        acc_w = ACC_W'(part_reg[0]) + ACC_W'(part_reg[1]);
        // toward zero: bias negative sums before the arithmetic shift
        quo_w = (acc_w + ((acc_w < 0) ? ROUND_NEG : ACC_W'(0))) >>> FRAC_BITS;
        if (quo_w > MAXV)
            sat_w = MAXV[SAMPLE_BITS-1:0];
        else if (quo_w < MINV)
            sat_w = MINV[SAMPLE_BITS-1:0];
        else
            sat_w = quo_w[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_PART])
        begin
            part_reg[0] <= part_w[0];
            part_reg[1] <= part_w[1];
        end
        if (en[STG_OUT])
            mixed_reg <= sat_w;
    end

    assign mixed = mixed_reg;

endmodule

// ----- sim/tb_trilinear_eight_source_mixer.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_trilinear_eight_source_mixer
// Self-checking bench for the trilinear eight-source mixer: a bit-exact
// fixed-point mix predictor runs beside the pipeline, every output word is
// compared with the oldest predicted word, and both channels idle, burst and
// stall at random across several axis settings.
// ============================================================================
module tb_trilinear_eight_source_mixer;

    import tsm_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int     SAMPLE_W        = 16;
    localparam int     FRAC            = 15;
    localparam longint ONE_Q           = 64'sd1 << FRAC;
    localparam longint HALF_Q          = 64'sd1 << (FRAC - 1);
    localparam longint SAMPLE_MAX      = (64'sd1 << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN      = -SAMPLE_MAX - 1;
    localparam int     LATENCY         = 7;
    localparam int     DRAIN_LIMIT     = 5000;
    localparam int     ITEMS_PER_PHASE = 145;
    localparam int     HOLD_OFF_CYCLES = 60;
    localparam int     MAX_REPORTS     = 10;
    localparam longint TIMEOUT_NS      = 64'd5_000_000;

    // unused slots on the cfg channel
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    // handy Q1.15 / 17-bit depth encodings
    localparam logic [16:0] Q_ZERO     = 17'h00000;
    localparam logic [16:0] Q_HALF     = 17'h04000;
    localparam logic [16:0] Q_ONE      = 17'h08000;
    localparam logic [16:0] D_MINUS_1  = 17'h18000;   // depth -1.0
    localparam logic [16:0] D_MOST_NEG = 17'h10000;   // depth -2.0
    localparam logic [16:0] D_MOST_POS = 17'h0FFFF;
    localparam logic [16:0] S_TOP      = 17'h0FFFF;   // start just under 2.0

    // receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_RUNS   = 2;

    typedef struct packed {
        logic [NUM_SRC-1:0][SAMPLE_W-1:0] src;
        logic [MASK_BITS-1:0]             mask;
        logic [MOD_BITS-1:0]              mod_x;
        logic [MOD_BITS-1:0]              mod_y;
        logic [MOD_BITS-1:0]              mod_z;
    } mix_word_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] source_0, source_1, source_2, source_3;
    logic signed [SAMPLE_W-1:0] source_4, source_5, source_6, source_7;
    logic [MASK_BITS-1:0]       active_mask;
    logic [MOD_BITS-1:0]        mod_x, mod_y, mod_z;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [2:0]                 cfg_index;
    logic [DEPTH_BITS-1:0]      cfg_data;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic [16:0]                axis_cfg [NUM_REGS];   // shadow of the axis registers
    logic signed [SAMPLE_W-1:0] mix_expected_q [$];    // predicted words, oldest first
    int                         err_count     = 0;
    int                         words_sent    = 0;
    int                         words_checked = 0;
    int                         cfg_writes    = 0;
    int                         input_stalls  = 0;
    int                         saturations   = 0;
    int                         burst_left    = 0;
    bit                         gaps_enabled  = 1'b1;
    int                         stall_mode    = STALL_NONE;
    int                         hold_off_left = 0;

    trilinear_eight_source_mixer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_0     (source_0),
        .source_1     (source_1),
        .source_2     (source_2),
        .source_3     (source_3),
        .source_4     (source_4),
        .source_5     (source_5),
        .source_6     (source_6),
        .source_7     (source_7),
        .active_mask  (active_mask),
        .mod_x        (mod_x),
        .mod_y        (mod_y),
        .mod_z        (mod_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mixed_sample (mixed_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Mix predictor
    // ------------------------------------------------------------------

    // start + round(depth * mod), clamped to 0..1.0; >>> on a signed
    // longint floors, which gives round half up after adding HALF_Q
    function automatic longint axis_position(input logic [16:0] start_r,
                                             input logic [16:0] depth_r,
                                             input logic [15:0] modv);
        longint st, dp, md, p;
        st = longint'(start_r[15:0]);
        dp = longint'($signed(depth_r));
        md = longint'(modv);
        p  = st + ((dp * md + HALF_Q) >>> FRAC);
        if (p < 0)
            p = 0;
        if (p > ONE_Q)
            p = ONE_Q;
        return p;
    endfunction

    // weight of one corner: far side uses the position, near side 1 - pos;
    // rounded after each of the two products
    function automatic longint corner_weight(input logic [2:0] c, input longint px,
                                             input longint py, input longint pz);
        longint wx, wy, wz, w;
        wx = c[0] ? px : ONE_Q - px;
        wy = c[1] ? py : ONE_Q - py;
        wz = c[2] ? pz : ONE_Q - pz;
        w  = (wx * wy + HALF_Q) >>> FRAC;
        w  = (w * wz + HALF_Q) >>> FRAC;
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] predict_mix(input mix_word_t w);
        longint px, py, pz, acc, res;
        int     n;
        px  = axis_position(axis_cfg[REG_X_START], axis_cfg[REG_X_DEPTH], w.mod_x);
        py  = axis_position(axis_cfg[REG_Y_START], axis_cfg[REG_Y_DEPTH], w.mod_y);
        pz  = axis_position(axis_cfg[REG_Z_START], axis_cfg[REG_Z_DEPTH], w.mod_z);
        acc = 0;
        for (n = 0; n < NUM_SRC; n++)
            if (w.mask[n])
                acc += corner_weight(CORNER_BITS[n], px, py, pz)
                       * longint'($signed(w.src[n]));
        // truncate toward zero, then clip
        res = (acc >= 0) ? (acc >>> FRAC) : -((-acc) >>> FRAC);
        if (res > SAMPLE_MAX || res < SAMPLE_MIN)
            saturations++;
        if (res > SAMPLE_MAX)
            res = SAMPLE_MAX;
        if (res < SAMPLE_MIN)
            res = SAMPLE_MIN;
        return res[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly 0..1.0, sometimes the full 16-bit range
    function automatic logic [15:0] random_mod();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic mix_word_t random_word();
        mix_word_t w;
        int        n;
        logic      neg;
        if ($urandom_range(0, 9) == 0)
        begin
            // all corners full scale with one sign, to push the sum to the rails
            neg = 1'($urandom);
            for (n = 0; n < NUM_SRC; n++)
                w.src[n] = neg ? 16'h8000 : 16'h7FFF;
            w.mask = 8'hFF;
        end
        else
        begin
            for (n = 0; n < NUM_SRC; n++)
                w.src[n] = random_sample();
            case ($urandom_range(0, 9))
                0:       w.mask = 8'hFF;
                1:       w.mask = 8'h00;
                default: w.mask = 8'($urandom);
            endcase
        end
        w.mod_x = random_mod();
        w.mod_y = random_mod();
        w.mod_z = random_mod();
        return w;
    endfunction

    // bit 16 on a start write is junk the register must drop
    function automatic logic [16:0] random_start();
        case ($urandom_range(0, 5))
            0:       return Q_ZERO;
            1:       return Q_ONE;
            2:       return 17'($urandom);
            default: return {1'($urandom), 16'($urandom_range(0, 32768))};
        endcase
    endfunction

    function automatic logic [16:0] random_depth();
        case ($urandom_range(0, 6))
            0:       return Q_ONE;
            1:       return D_MINUS_1;
            2:       return 17'($urandom);
            3:       return Q_ZERO;
            default: return 17'(int'($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    function automatic mix_word_t make_word(input logic [15:0] base, input logic [7:0] mask,
                                            input logic [15:0] mx, input logic [15:0] my,
                                            input logic [15:0] mz);
        mix_word_t w;
        int        n;
        for (n = 0; n < NUM_SRC; n++)
            w.src[n] = base + 16'(n * 1111);
        w.mask  = mask;
        w.mod_x = mx;
        w.mod_y = my;
        w.mod_z = mz;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Input channel: offer one word, bursts with random gaps between them
    // ------------------------------------------------------------------
    task automatic send_word(input mix_word_t w);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gaps_enabled)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        source_0    = w.src[0];
        source_1    = w.src[1];
        source_2    = w.src[2];
        source_3    = w.src[3];
        source_4    = w.src[4];
        source_5    = w.src[5];
        source_6    = w.src[6];
        source_7    = w.src[7];
        active_mask = w.mask;
        mod_x       = w.mod_x;
        mod_y       = w.mod_y;
        mod_z       = w.mod_z;
        in_valid    = 1'b1;
        // hold the word until the block takes it
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
            input_stalls++;
        end
        mix_expected_q.push_back(predict_mix(w));
        words_sent++;
    endtask

    // stop offering and wait for every predicted word, then let the pipe empty
    task automatic drain_pipe();
        int n;
        n = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (mix_expected_q.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (mix_expected_q.size() != 0)
        begin
            err_count += mix_expected_q.size();
            $display("%0t: %0d words never came out", $realtime, mix_expected_q.size());
            mix_expected_q.delete();
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        // odd indexes are 17-bit depths, even ones 16-bit starts
        if (idx < NUM_REGS)
            axis_cfg[idx] = idx[0] ? data : {1'b0, data[15:0]};
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_axes(input logic [16:0] xs, input logic [16:0] xd,
                            input logic [16:0] ys, input logic [16:0] yd,
                            input logic [16:0] zs, input logic [16:0] zd);
        write_reg(REG_X_START, xs);
        write_reg(REG_X_DEPTH, xd);
        write_reg(REG_Y_START, ys);
        write_reg(REG_Y_DEPTH, yd);
        write_reg(REG_Z_START, zs);
        write_reg(REG_Z_DEPTH, zd);
    endtask

    // ------------------------------------------------------------------
    // Output channel: stall pattern, plus a counted hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int run_left;
        bit run_stall;
        run_left  = 0;
        run_stall = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                out_stall = 1'b1;
                hold_off_left--;
            end
            else
            begin
                case (stall_mode)
                    STALL_RANDOM: out_stall = ($urandom_range(0, 3) == 0);
                    STALL_RUNS:
                    begin
                        if (run_left == 0)
                        begin
                            run_stall = !run_stall;
                            run_left  = run_stall ? $urandom_range(1, 8)
                                                  : $urandom_range(1, 10);
                        end
                        run_left--;
                        out_stall = run_stall;
                    end
                    default: out_stall = 1'b0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: every word taken from the output goes against the oldest
    // prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (mix_expected_q.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected output word %0d", $realtime, mixed_sample);
            end
            else
            begin
                want = mix_expected_q.pop_front();
                if (mixed_sample !== want)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: word %0d mixed_sample expected %0d got %0d",
                                 $realtime, words_checked, want, mixed_sample);
                end
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // registers at reset: all positions 0, so only corner (0,0,0) counts
    task automatic test_reset_defaults();
        send_word(make_word(16'h7FFF, 8'hFF, 16'd0, 16'd0, 16'd0));
        send_word(make_word(16'h8000, 8'h01, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(make_word(16'h1234, 8'hFE, 16'd32768, 16'd0, 16'd12345));
    endtask

    // park the axes on each cube corner in turn; one source wins each time
    task automatic test_corners();
        int c;
        for (c = 0; c < NUM_SRC; c++)
        begin
            drain_pipe();
            set_axes(c[0] ? Q_ONE : Q_ZERO, Q_ZERO,
                     c[1] ? Q_ONE : Q_ZERO, Q_ZERO,
                     c[2] ? Q_ONE : Q_ZERO, Q_ZERO);
            send_word(make_word(16'(-20000 + c * 3000), 8'hFF, 16'd0, 16'd0, 16'd0));
        end
    endtask

    // depth/modulator extremes, rounding at the half step, out-of-range clamps
    task automatic test_modulation();
        drain_pipe();
        set_axes(Q_ZERO, Q_ONE, Q_ONE, D_MINUS_1, Q_HALF, 17'd1);
        send_word(make_word(16'd3000, 8'hFF, 16'd32768, 16'd32768, 16'd16384));
        send_word(make_word(16'hC000, 8'hFF, 16'd0, 16'd0, 16'd0));
        send_word(make_word(16'd700, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        drain_pipe();
        // depth of -1 LSB: half step rounds up to 0, a hair past it floors to -1
        set_axes(S_TOP, D_MOST_NEG, Q_ZERO, D_MOST_POS, Q_HALF, 17'h1FFFF);
        send_word(make_word(16'd9000, 8'hFF, 16'd16384, 16'd16384, 16'd16384));
        send_word(make_word(16'hA000, 8'hFF, 16'hFFFF, 16'd1, 16'd16385));
        send_word(make_word(16'd5, 8'h00, 16'd100, 16'd200, 16'd300));
    endtask

    // look for a position whose rounded weights add past 1.0, so full-scale
    // corners overflow the sum and hit the rails
    task automatic test_saturation();
        longint p, best, sum;
        int     c;
        best = 64'sd16384;
        for (p = 1; p < ONE_Q; p++)
        begin
            sum = 0;
            for (c = 0; c < NUM_SRC; c++)
                sum += corner_weight(3'(c), p, p, p);
            if (sum > ONE_Q)
            begin
                best = p;
                break;
            end
        end
        drain_pipe();
        set_axes(17'(best), Q_ZERO, 17'(best), Q_ZERO, 17'(best), Q_ZERO);
        send_word({{NUM_SRC{16'h7FFF}}, 8'hFF, 16'd0, 16'd0, 16'd0});
        send_word({{NUM_SRC{16'h8000}}, 8'hFF, 16'd0, 16'd0, 16'd0});
    endtask

    // writes to the unused indexes must leave the axes alone
    task automatic test_unknown_index();
        drain_pipe();
        set_axes(17'd10000, 17'd5000, 17'd20000, D_MINUS_1, 17'd30000, 17'd12000);
        write_reg(REG_SPARE_6, 17'h1FFFF);
        write_reg(REG_SPARE_7, 17'h00000);
        send_word(make_word(16'd4321, 8'hFF, 16'd20000, 16'd10000, 16'd5000));
    endtask

    // receiver holds off for a long stretch while words keep coming, so the
    // pipe fills and in_stall must rise; then everything drains
    task automatic test_backpressure();
        drain_pipe();
        stall_mode    = STALL_NONE;
        gaps_enabled  = 1'b0;
        burst_left    = 0;
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (40) send_word(random_word());
        drain_pipe();
    endtask

    // random words across several axis settings and idle patterns
    task automatic test_random_phases();
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            drain_pipe();
            case (phase)
                0:       set_axes(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
                1:       set_axes(Q_ZERO, D_MINUS_1, Q_ZERO, D_MINUS_1, Q_ZERO, D_MINUS_1);
                2:       set_axes(S_TOP, D_MOST_NEG, S_TOP, D_MOST_POS, Q_ZERO, D_MOST_NEG);
                default: set_axes(random_start(), random_depth(), random_start(),
                                  random_depth(), random_start(), random_depth());
            endcase
            // phase 3 runs flat out: no gaps, no stalls
            stall_mode   = phase % 3;
            gaps_enabled = (phase != 3);
            burst_left   = 0;
            repeat (ITEMS_PER_PHASE) send_word(random_word());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        source_0    = '0;
        source_1    = '0;
        source_2    = '0;
        source_3    = '0;
        source_4    = '0;
        source_5    = '0;
        source_6    = '0;
        source_7    = '0;
        active_mask = '0;
        mod_x       = '0;
        mod_y       = '0;
        mod_z       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        for (int i = 0; i < NUM_REGS; i++)
            axis_cfg[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_corners();
        test_modulation();
        test_saturation();
        test_unknown_index();
        test_backpressure();
        test_random_phases();
        drain_pipe();

        $display("run covered %0d words (%0d checked), %0d register writes, %0d clipped sums",
                 words_sent, words_checked, cfg_writes, saturations);
        $display("input held off for %0d cycles, %0d failures", input_stalls, err_count);
        if (err_count == 0)
            $display("tb_trilinear_eight_source_mixer: clean");
        else
            $display("tb_trilinear_eight_source_mixer: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d words outstanding", mix_expected_q.size());
        $display("tb_trilinear_eight_source_mixer: errors");
        $finish;
    end

endmodule

// ----- trilinear_eight_source_mixer.f -----
rtl/tsm_pkg.sv
rtl/tsm_axis.sv
rtl/tsm_lane.sv
rtl/tsm_merge.sv
rtl/trilinear_eight_source_mixer.sv
sim/tb_trilinear_eight_source_mixer.sv
